FILE: hdl/fst_node_record_decoder_unit_macros.svh
// Assertion macros for the node record decoder.
`ifndef FST_NODE_RECORD_DECODER_UNIT_MACROS_SVH
`define FST_NODE_RECORD_DECODER_UNIT_MACROS_SVH

// Concurrent check, quiet while reset is high.
`define FNRD_CHECK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Concurrent check that also holds while reset is high.
`define FNRD_CHECK_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

FILE: hdl/fnrd_pkg.sv
// Shared types, constants and helpers of the node record decoder.
`timescale 1ns / 1ps
package fnrd_pkg;

  // Type byte layout
  localparam int FinalBitPos    = 0;
  localparam int CountCodeLsb   = 1;
  localparam int FinalOutBitPos = 3;

  // Result kinds
  localparam logic ItemHeader     = 1'b0;
  localparam logic ItemTransition = 1'b1;

  localparam int ValueW  = 64;
  localparam int TdataW  = 216;

  typedef struct packed {
    logic              item_kind;
    logic              is_final;
    logic              final_value_present;
    logic [ValueW-1:0] final_value;
    logic [7:0]        transition_count;
    logic [7:0]        label;
    logic [ValueW-1:0] transition_value;
    logic [ValueW-1:0] target_offset;
    logic              last_of_node;
  } result_t;

  function automatic result_t make_header(input logic ff, input logic fvf,
                                          input logic [ValueW-1:0] fval,
                                          input logic [7:0] cnt, input logic last);
    result_t r;
    r                     = '0;
    r.item_kind           = ItemHeader;
    r.is_final            = ff;
    r.final_value_present = fvf;
    r.final_value         = fvf ? fval : '0;
    r.transition_count    = cnt;
    r.last_of_node        = last;
    return r;
  endfunction

  function automatic logic [TdataW-1:0] pack_tdata(input result_t r);
    return {6'd0, r.target_offset, r.transition_value, r.label, r.transition_count,
            r.final_value, r.final_value_present, r.is_final};
  endfunction

endpackage

FILE: hdl/fst_node_record_decoder_unit.sv
// Node record decoder: serialized transducer node bytes in, header and transitions out.
// Input stream: one record byte per transfer on s_axis_tdata, s_axis_tuser set on the
// type byte that opens a record. A start mark in mid-record restarts decoding; bytes
// seen while idle without a start mark are dropped.
// Output stream: one node header (m_axis_tuser 0) once the header bytes are in, then one
// transition (m_axis_tuser 1) per label/output/target group; m_axis_tlast marks the
// last result of the record.
// Config channel: cfg_data sets has_output (reset 1); write it only while idle.
// Data path: a byte is held in the input register and is decoded into the result
// register; the decode step between the two registers is combinational.
// One byte is taken every cycle unless the receiver stalls with a result pending.
// Reset clears the parser to idle and empties both registers.
// When the receiver stalls, the result register holds, the input register fills, and
// s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps
`include "fst_node_record_decoder_unit_macros.svh"
module fst_node_record_decoder_unit
  import fnrd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic              s_axis_tuser,   // [0] start_record
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [0] is_final, [1] final_value_present, [65:2] final_value, [73:66] transition_count,
  // [81:74] label, [145:82] transition_value, [209:146] target_offset, [215:210] zero
  output logic [TdataW-1:0] m_axis_tdata,
  output logic              m_axis_tuser,   // [0] item_kind
  output logic              m_axis_tlast,   // last_of_node
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data        // has_output
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_FINAL, PH_COUNT, PH_LABEL, PH_TOUT, PH_TADDR
  } phase_t;

  logic              in_valid, in_start;
  logic [7:0]        in_byte;
  logic              has_output;

  phase_t            phase, phase_next;
  logic [2:0]        byte_index, byte_index_next;
  logic [ValueW-1:0] value_shift, value_shift_next;
  logic              final_flag, final_flag_next;
  logic              final_value_flag, final_value_flag_next;
  logic [1:0]        count_code, count_code_next;
  logic [7:0]        remaining, remaining_next;
  logic [7:0]        held_label, held_label_next;
  logic [ValueW-1:0] held_output, held_output_next;

  logic              out_valid;
  result_t           out_item;

  logic              advance, process, emit;
  result_t           res_next;
  logic              by_code;
  logic [ValueW-1:0] by_code_fval;
  logic [ValueW-1:0] value_cat;
  logic              last_byte;
  logic [7:0]        rem_dec;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign process       = in_valid && advance;
  assign cfg_ready     = 1'b1;

  // Bytes arrive little-endian: shift each new byte in from the top.
  assign value_cat = {in_byte, value_shift[ValueW-1:8]};
  assign last_byte = (byte_index == 3'd7);
  assign rem_dec   = remaining - 8'd1;

  always_comb begin
    phase_next            = phase;
    byte_index_next       = byte_index;
    value_shift_next      = value_shift;
    final_flag_next       = final_flag;
    final_value_flag_next = final_value_flag;
    count_code_next       = count_code;
    remaining_next        = remaining;
    held_label_next       = held_label;
    held_output_next      = held_output;
    emit                  = 1'b0;
    res_next              = '0;
    by_code               = 1'b0;
    by_code_fval          = '0;

    if (in_start) begin
      final_flag_next       = in_byte[FinalBitPos];
      count_code_next       = in_byte[CountCodeLsb +: 2];
      final_value_flag_next = has_output && in_byte[FinalOutBitPos];
      byte_index_next       = '0;
      value_shift_next      = '0;
      remaining_next        = '0;
      held_label_next       = '0;
      held_output_next      = '0;
      if (final_value_flag_next) begin
        phase_next = PH_FINAL;
      end else if (count_code_next[1]) begin
        phase_next = PH_COUNT;
      end else begin
        by_code = 1'b1;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          // drop stray bytes
        end
        PH_FINAL: begin
          byte_index_next = byte_index + 3'd1;
          if (last_byte) begin
            held_output_next = value_cat;
            value_shift_next = '0;
            if (count_code[1]) begin
              phase_next = PH_COUNT;
            end else begin
              by_code      = 1'b1;
              by_code_fval = value_cat;
            end
          end else begin
            value_shift_next = value_cat;
          end
        end
        PH_COUNT: begin
          emit           = 1'b1;
          res_next       = make_header(final_flag, final_value_flag, held_output, in_byte,
                                       in_byte == 8'd0);
          remaining_next = in_byte;
          phase_next     = (in_byte == 8'd0) ? PH_IDLE : PH_LABEL;
        end
        PH_LABEL: begin
          held_label_next  = in_byte;
          held_output_next = '0;
          byte_index_next  = '0;
          value_shift_next = '0;
          phase_next       = has_output ? PH_TOUT : PH_TADDR;
        end
        PH_TOUT: begin
          byte_index_next = byte_index + 3'd1;
          if (last_byte) begin
            held_output_next = value_cat;
            value_shift_next = '0;
            phase_next       = PH_TADDR;
          end else begin
            value_shift_next = value_cat;
          end
        end
        PH_TADDR: begin
          byte_index_next = byte_index + 3'd1;
          if (last_byte) begin
            remaining_next            = rem_dec;
            emit                      = 1'b1;
            res_next.item_kind        = ItemTransition;
            res_next.label            = held_label;
            res_next.transition_value = held_output;
            res_next.target_offset    = value_cat;
            res_next.last_of_node     = (rem_dec == 8'd0);
            value_shift_next          = '0;
            phase_next                = (rem_dec == 8'd0) ? PH_IDLE : PH_LABEL;
          end else begin
            value_shift_next = value_cat;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    // Header complete with the count taken from the two-bit code.
    if (by_code) begin
      emit = 1'b1;
      if (count_code_next == 2'd0) begin
        res_next   = make_header(final_flag_next, final_value_flag_next, by_code_fval,
                                 8'd0, 1'b1);
        phase_next = PH_IDLE;
      end else begin
        res_next       = make_header(final_flag_next, final_value_flag_next, by_code_fval,
                                     8'd1, 1'b0);
        remaining_next = 8'd1;
        phase_next     = PH_LABEL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      has_output       <= 1'b1;
      phase            <= PH_IDLE;
      byte_index       <= '0;
      value_shift      <= '0;
      final_flag       <= 1'b0;
      final_value_flag <= 1'b0;
      count_code       <= '0;
      remaining        <= '0;
      held_label       <= '0;
      held_output      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        has_output <= cfg_data;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (process) begin
        phase            <= phase_next;
        byte_index       <= byte_index_next;
        value_shift      <= value_shift_next;
        final_flag       <= final_flag_next;
        final_value_flag <= final_value_flag_next;
        count_code       <= count_code_next;
        remaining        <= remaining_next;
        held_label       <= held_label_next;
        held_output      <= held_output_next;
      end
      if (advance) begin
        out_valid <= process && emit;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
    if (process && emit) begin
      out_item <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = pack_tdata(out_item);
  assign m_axis_tuser  = out_item.item_kind;
  assign m_axis_tlast  = out_item.last_of_node;

  `FNRD_CHECK(a_empty_header_last, clk, rst, (out_valid && out_item.item_kind == ItemHeader && out_item.transition_count == 8'd0) |-> out_item.last_of_node, "header with no transitions not marked last")
  `FNRD_CHECK(a_trans_no_header_flags, clk, rst, (out_valid && out_item.item_kind == ItemTransition) |-> (!out_item.is_final && !out_item.final_value_present && out_item.transition_count == 8'd0), "transition carries header fields")
  `FNRD_CHECK(a_idle_nothing_pending, clk, rst, (phase == PH_IDLE) |-> (remaining == 8'd0), "idle with transitions still pending")
  `FNRD_CHECK_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "result valid right after reset")

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the transducer node record decoder.
`timescale 1ns / 1ps
module tb;
  import fnrd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FINAL, PH_COUNT, PH_LABEL, PH_TOUT, PH_TADDR
  } parse_phase_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } record_byte_t;

  localparam int SettleCycles = 8;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_data;

  fst_node_record_decoder_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decoder model state
  parse_phase_t p_phase;
  logic [2:0]   p_idx;
  logic [63:0]  p_shift;
  logic         p_final;
  logic         p_fvf;
  logic [1:0]   p_code;
  logic [7:0]   p_remaining;
  logic [7:0]   p_label;
  logic [63:0]  p_held;
  logic         cfg_has_output;

  result_t      expected_results[$];
  record_byte_t pending_bytes[$];
  int           decoded_bytes;
  int           error_count;
  int           results_seen;
  bit           quiet_mode;

  function automatic bit idle_roll();
    return !quiet_mode && ($urandom_range(0, 99) < 7);
  endfunction

  function automatic bit take_value_byte(input logic [7:0] b);
    p_shift = p_shift | ({56'd0, b} << {p_idx, 3'b000});
    if (p_idx == 3'd7) begin
      p_idx = 3'd0;
      return 1'b1;
    end
    p_idx = p_idx + 3'd1;
    return 1'b0;
  endfunction

  function automatic void push_header(input logic [63:0] fval, input logic [7:0] cnt,
                                      input logic last);
    result_t r;
    r                     = '0;
    r.item_kind           = ItemHeader;
    r.is_final            = p_final;
    r.final_value_present = p_fvf;
    r.final_value         = p_fvf ? fval : 64'd0;
    r.transition_count    = cnt;
    r.last_of_node        = last;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void header_from_code(input logic [63:0] fval);
    if (p_code == 2'd0) begin
      push_header(fval, 8'd0, 1'b1);
      p_phase = PH_IDLE;
    end else begin
      push_header(fval, 8'd1, 1'b0);
      p_remaining = 8'd1;
      p_phase     = PH_LABEL;
    end
  endfunction

  // Advance the model by one accepted byte and queue what it produces.
  function automatic void predict_record_byte(input logic [7:0] b, input logic st);
    result_t r;
    if (st || p_phase != PH_IDLE) decoded_bytes++;
    if (st) begin
      p_final     = b[FinalBitPos];
      p_code      = b[CountCodeLsb +: 2];
      p_fvf       = cfg_has_output && b[FinalOutBitPos];
      p_idx       = 3'd0;
      p_shift     = 64'd0;
      p_remaining = 8'd0;
      p_label     = 8'd0;
      p_held      = 64'd0;
      if (p_fvf) p_phase = PH_FINAL;
      else if (p_code >= 2'd2) p_phase = PH_COUNT;
      else header_from_code(64'd0);
      return;
    end
    case (p_phase)
      PH_FINAL: begin
        if (take_value_byte(b)) begin
          p_held  = p_shift;
          p_shift = 64'd0;
          if (p_code >= 2'd2) p_phase = PH_COUNT;
          else header_from_code(p_held);
        end
      end
      PH_COUNT: begin
        push_header(p_held, b, b == 8'd0);
        p_remaining = b;
        p_phase     = (b == 8'd0) ? PH_IDLE : PH_LABEL;
      end
      PH_LABEL: begin
        p_label = b;
        p_held  = 64'd0;
        p_idx   = 3'd0;
        p_shift = 64'd0;
        p_phase = cfg_has_output ? PH_TOUT : PH_TADDR;
      end
      PH_TOUT: begin
        if (take_value_byte(b)) begin
          p_held  = p_shift;
          p_shift = 64'd0;
          p_phase = PH_TADDR;
        end
      end
      PH_TADDR: begin
        if (take_value_byte(b)) begin
          p_remaining        = p_remaining - 8'd1;
          r                  = '0;
          r.item_kind        = ItemTransition;
          r.label            = p_label;
          r.transition_value = p_held;
          r.target_offset    = p_shift;
          r.last_of_node     = (p_remaining == 8'd0);
          expected_results.insert(expected_results.size(), r);
          p_shift = 64'd0;
          p_phase = (p_remaining == 8'd0) ? PH_IDLE : PH_LABEL;
        end
      end
      default: p_phase = PH_IDLE;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
    error_count++;
  endtask

  task automatic compare_result();
    result_t e;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result", {48'd0, m_axis_tdata[15:0]}, 64'd0);
      return;
    end
    e = expected_results.pop_front();
    if (m_axis_tuser !== e.item_kind)
      report_mismatch("item_kind", 64'(m_axis_tuser), 64'(e.item_kind));
    if (m_axis_tdata[0] !== e.is_final)
      report_mismatch("is_final", 64'(m_axis_tdata[0]), 64'(e.is_final));
    if (m_axis_tdata[1] !== e.final_value_present)
      report_mismatch("final_value_present", 64'(m_axis_tdata[1]),
                      64'(e.final_value_present));
    if (m_axis_tdata[65:2] !== e.final_value)
      report_mismatch("final_value", m_axis_tdata[65:2], e.final_value);
    if (m_axis_tdata[73:66] !== e.transition_count)
      report_mismatch("transition_count", 64'(m_axis_tdata[73:66]),
                      64'(e.transition_count));
    if (m_axis_tdata[81:74] !== e.label)
      report_mismatch("label", 64'(m_axis_tdata[81:74]), 64'(e.label));
    if (m_axis_tdata[145:82] !== e.transition_value)
      report_mismatch("transition_value", m_axis_tdata[145:82], e.transition_value);
    if (m_axis_tdata[209:146] !== e.target_offset)
      report_mismatch("target_offset", m_axis_tdata[209:146], e.target_offset);
    if (m_axis_tdata[215:210] !== 6'd0)
      report_mismatch("pad bits", 64'(m_axis_tdata[215:210]), 64'd0);
    if (m_axis_tlast !== e.last_of_node)
      report_mismatch("last_of_node", 64'(m_axis_tlast), 64'(e.last_of_node));
  endtask

  always @(negedge clk) m_axis_tready <= !idle_roll();

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      compare_result();
      results_seen++;
    end
  end

  // Hold the byte until its transfer; valid stays high into the next byte.
  task automatic send_byte(input logic [7:0] b, input logic st);
    @(negedge clk);
    while (idle_roll()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk); while (!s_axis_tready);
    predict_record_byte(b, st);
  endtask

  function automatic void queue_byte(input logic [7:0] b, input logic st);
    record_byte_t rb;
    rb.data  = b;
    rb.start = st;
    pending_bytes.insert(pending_bytes.size(), rb);
  endfunction

  function automatic void queue_value(input logic [63:0] v);
    for (int i = 0; i < 8; i++) queue_byte(v[8*i +: 8], 1'b0);
  endfunction

  function automatic void queue_transition(input logic [7:0] lbl, input logic [63:0] outv,
                                           input logic [63:0] target);
    queue_byte(lbl, 1'b0);
    if (cfg_has_output) queue_value(outv);
    queue_value(target);
  endfunction

  function automatic logic [63:0] random_value64();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return AllOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic flush_bytes();
    record_byte_t rb;
    while (pending_bytes.size() != 0) begin
      rb = pending_bytes.pop_front();
      send_byte(rb.data, rb.start);
    end
  endtask

  // Drop valid, wait for every expected result, then let the input register settle.
  task automatic drain_pipeline();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_has_output(input logic v);
    drain_pipeline();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_has_output = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_headers_by_code();
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h01, 1'b1);
    // final value present, junk in the upper type bits
    queue_byte(8'hF9, 1'b1);
    queue_value(AllOnes);
    queue_byte(8'h0B, 1'b1);
    queue_value(64'd0);
    queue_transition(8'hFF, AllOnes, AllOnes);
    queue_byte(8'h03, 1'b1);
    queue_transition(8'h00, 64'd0, 64'd0);
    flush_bytes();
    drain_pipeline();
  endtask

  task automatic test_explicit_count();
    // explicit count of zero closes the record at the header
    queue_byte(8'h04, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h0E, 1'b1);
    queue_value(64'h0123_4567_89AB_CDEF);
    queue_byte(8'd2, 1'b0);
    queue_transition(8'h5A, 64'h8000_0000_0000_0001, 64'hFEDC_BA98_7654_3210);
    queue_transition(8'hA5, 64'd0, 64'h0000_0000_0000_0080);
    // count code three behaves like two
    queue_byte(8'h06, 1'b1);
    queue_byte(8'd1, 1'b0);
    queue_transition(8'h80, random_value64(), random_value64());
    flush_bytes();
    drain_pipeline();
  endtask

  task automatic test_outputs_off();
    write_has_output(1'b0);
    // final-output flag is ignored with outputs off
    queue_byte(8'h0F, 1'b1);
    queue_byte(8'd20, 1'b0);
    for (int i = 0; i < 20; i++)
      queue_transition(8'($urandom_range(0, 255)), 64'd0, random_value64());
    queue_byte(8'h08, 1'b1);
    flush_bytes();
    drain_pipeline();
  endtask

  task automatic test_restart_and_drop();
    write_has_output(1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h0A, 1'b1);
    for (int i = 0; i < 3; i++) queue_byte(8'($urandom_range(0, 255)), 1'b0);
    queue_byte(8'h02, 1'b1);
    queue_byte(8'h33, 1'b0);
    for (int i = 0; i < 5; i++) queue_byte(8'($urandom_range(0, 255)), 1'b0);
    queue_byte(8'h00, 1'b1);
    flush_bytes();
    drain_pipeline();
  endtask

  task automatic test_mid_record_config();
    queue_byte(8'h02, 1'b1);
    flush_bytes();
    write_has_output(1'b0);
    queue_transition(8'hC3, AllOnes, 64'h1122_3344_5566_7788);
    flush_bytes();
    queue_byte(8'h02, 1'b1);
    flush_bytes();
    write_has_output(1'b1);
    queue_transition(8'h3C, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0);
    flush_bytes();
    drain_pipeline();
  endtask

  function automatic void queue_random_record();
    logic [7:0] type_byte;
    logic [7:0] cnt;
    int         n;
    type_byte = 8'($urandom_range(0, 255));
    queue_byte(type_byte, 1'b1);
    if (cfg_has_output && type_byte[FinalOutBitPos]) queue_value(random_value64());
    case (type_byte[CountCodeLsb +: 2])
      2'd0:    n = 0;
      2'd1:    n = 1;
      default: begin
        cnt = ($urandom_range(0, 99) < 4) ? 8'($urandom_range(5, 12))
                                          : 8'($urandom_range(0, 4));
        queue_byte(cnt, 1'b0);
        n = int'(cnt);
      end
    endcase
    for (int i = 0; i < n; i++)
      queue_transition(8'($urandom_range(0, 255)), random_value64(), random_value64());
  endfunction

  // Mostly well-formed records; some noise bytes and records cut short.
  task automatic test_random_records(input int byte_target, input logic has_out,
                                     input bit no_idle);
    int start_count;
    int roll;
    int keep;
    write_has_output(has_out);
    quiet_mode  = no_idle;
    start_count = decoded_bytes;
    while (decoded_bytes - start_count < byte_target) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        queue_random_record();
        if (roll < 18 && pending_bytes.size() > 1) begin
          keep = $urandom_range(1, pending_bytes.size() - 1);
          while (pending_bytes.size() > keep) pending_bytes.delete(pending_bytes.size() - 1);
        end
      end
      flush_bytes();
    end
    drain_pipeline();
    quiet_mode = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'd0;
    s_axis_tuser   = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = 1'b0;
    cfg_has_output = 1'b1;
    p_phase        = PH_IDLE;
    p_idx          = 3'd0;
    p_shift        = 64'd0;
    p_final        = 1'b0;
    p_fvf          = 1'b0;
    p_code         = 2'd0;
    p_remaining    = 8'd0;
    p_label        = 8'd0;
    p_held         = 64'd0;
    decoded_bytes  = 0;
    error_count    = 0;
    results_seen   = 0;
    quiet_mode     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_headers_by_code();
    test_explicit_count();
    test_outputs_off();
    test_restart_and_drop();
    test_mid_record_config();
    test_random_records(160, 1'b1, 1'b0);
    test_random_records(120, 1'b0, 1'b0);
    test_random_records(80, 1'b1, 1'b1);
    test_random_records(100, 1'($urandom_range(0, 1)), 1'b0);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/fnrd_pkg.sv
hdl/fst_node_record_decoder_unit.sv
verif/tb.sv
